// File: hdl/cgpc_pkg.sv
// ----------------------------------------------------------------------------
// cgpc_pkg
// Shared types and constants of the current gated pulse controller.
// ----------------------------------------------------------------------------
package cgpc_pkg;

  // Register widths
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned BLINK_W = 20;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned PHASE_W = 3;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] CFG_PULSE_LENGTH    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_COOLDOWN_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] CFG_BLINK_PERIOD    = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0]   PULSE_LENGTH_RST    = 16'd50;
  localparam logic [LEN_W-1:0]   COOLDOWN_LENGTH_RST = 16'd500;
  localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST    = 20'd500000;

  // Phase codes as reported on the result word
  localparam logic [PHASE_W-1:0] CODE_CHECK = 3'd0;
  localparam logic [PHASE_W-1:0] CODE_WAIT  = 3'd1;
  localparam logic [PHASE_W-1:0] CODE_ARMED = 3'd2;
  localparam logic [PHASE_W-1:0] CODE_PULSE = 3'd3;
  localparam logic [PHASE_W-1:0] CODE_COOL  = 3'd4;
  localparam logic [PHASE_W-1:0] CODE_ERROR = 3'd5;

  // Controller phase, one-hot
  typedef enum logic [5:0] {
    PH_CHECK = 6'b000001,
    PH_WAIT  = 6'b000010,
    PH_ARMED = 6'b000100,
    PH_PULSE = 6'b001000,
    PH_COOL  = 6'b010000,
    PH_ERROR = 6'b100000
  } phase_e;

  typedef struct packed {
    logic enable_level;
    logic current_level;
  } in_t;

  typedef struct packed {
    logic               gate_drive;
    logic               status_led;
    logic               fault_latched;
    logic [PHASE_W-1:0] phase_now;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]   pulse_length;
    logic [LEN_W-1:0]   cooldown_length;
    logic [BLINK_W-1:0] blink_period;
  } cfg_t;

  // One-hot phase to reported code
  function automatic logic [PHASE_W-1:0] phase_code(phase_e ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_WAIT:  code = CODE_WAIT;
      PH_ARMED: code = CODE_ARMED;
      PH_PULSE: code = CODE_PULSE;
      PH_COOL:  code = CODE_COOL;
      PH_ERROR: code = CODE_ERROR;
      default:  code = CODE_CHECK;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/cgpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// cgpc_cfg_regs
// Configuration registers: pulse length, cooldown length, blink period.
// ----------------------------------------------------------------------------
module cgpc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cgpc_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [cgpc_pkg::BLINK_W-1:0]     cfg_data_i,
  output cgpc_pkg::cfg_t                   cfg_o
);
  import cgpc_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_length    <= PULSE_LENGTH_RST;
      cfg_q.cooldown_length <= COOLDOWN_LENGTH_RST;
      cfg_q.blink_period    <= BLINK_PERIOD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PULSE_LENGTH:    cfg_q.pulse_length    <= cfg_data_i[LEN_W-1:0];
        CFG_COOLDOWN_LENGTH: cfg_q.cooldown_length <= cfg_data_i[LEN_W-1:0];
        CFG_BLINK_PERIOD:    cfg_q.blink_period    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/cgpc_fsm.sv
// ----------------------------------------------------------------------------
// cgpc_fsm
// Phase machine with tick counter, gate and LED state. Advances one step per
// accepted tick word and presents the resulting status word.
// ----------------------------------------------------------------------------
module cgpc_fsm #(
  parameter int unsigned COUNTER_BITS = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  cgpc_pkg::in_t   in_i,
  input  cgpc_pkg::cfg_t  cfg_i,
  output cgpc_pkg::out_t  res_o
);
  import cgpc_pkg::*;

  localparam int unsigned CMP_W = (COUNTER_BITS > BLINK_W) ? COUNTER_BITS : BLINK_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  phase_e                  phase_q, phase_d;
  logic [COUNTER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                    led_q, led_d;
  logic                    gate_q, gate_d;
  logic [BLINK_W-1:0]      lim_raw, lim;
  logic                    reaches;

  // Limit for the counting phase; zero acts as one
  always_comb begin
    case (phase_q)
      PH_PULSE: lim_raw = BLINK_W'(cfg_i.pulse_length);
      PH_COOL:  lim_raw = BLINK_W'(cfg_i.cooldown_length);
      default:  lim_raw = cfg_i.blink_period;
    endcase
    lim = (lim_raw == '0) ? BLINK_W'(1) : lim_raw;
  end

  // Saturating increment; a limit past the counter range stops at full scale
  assign cnt_inc = (cnt_q != CNT_MAX) ? cnt_q + COUNTER_BITS'(1) : cnt_q;
  assign reaches = (CMP_W'(cnt_inc) >= CMP_W'(lim)) || (cnt_inc == CNT_MAX);

  // Next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    led_d   = led_q;
    gate_d  = gate_q;
    case (phase_q)
      PH_WAIT: begin
        if (in_i.enable_level) begin
          gate_d  = 1'b1;
          phase_d = PH_ARMED;
        end
      end
      PH_ARMED: begin
        if (in_i.current_level) begin
          cnt_d   = '0;
          phase_d = PH_PULSE;
        end else if (!in_i.enable_level) begin
          gate_d  = 1'b0;
          cnt_d   = '0;
          phase_d = PH_COOL;
        end
      end
      PH_PULSE: begin
        cnt_d = cnt_inc;
        if (reaches) begin
          gate_d  = 1'b0;
          cnt_d   = '0;
          phase_d = PH_COOL;
        end
      end
      PH_COOL: begin
        cnt_d = cnt_inc;
        if (reaches) begin
          cnt_d   = '0;
          phase_d = PH_CHECK;
        end
      end
      PH_ERROR: begin
        gate_d = 1'b0;
        cnt_d  = cnt_inc;
        if (reaches) begin
          led_d = ~led_q;
          cnt_d = '0;
        end
      end
      default: begin
        // check: current with the gate off is a fault
        if (in_i.current_level) begin
          gate_d  = 1'b0;
          cnt_d   = '0;
          phase_d = PH_ERROR;
        end else begin
          phase_d = PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CHECK;
      cnt_q   <= '0;
      led_q   <= 1'b1;
      gate_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      led_q   <= led_d;
      gate_q  <= gate_d;
    end
  end

  // Status word shows the state after this tick
  assign res_o.gate_drive    = gate_d;
  assign res_o.status_led    = led_d;
  assign res_o.fault_latched = (phase_d == PH_ERROR);
  assign res_o.phase_now     = phase_code(phase_d);

endmodule

// File: hdl/cgpc_out_buf.sv
// ----------------------------------------------------------------------------
// cgpc_out_buf
// Result register with a skid entry. The upstream stall is registered, so a
// new word is taken while one waits on a stalled output.
// ----------------------------------------------------------------------------
module cgpc_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cgpc_pkg::out_t  data_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cgpc_pkg::out_t  out_data_o
);
  import cgpc_pkg::*;

  logic head_valid_q, skid_valid_q;
  out_t head_q, skid_q;
  logic pop, head_free;

  assign pop       = head_valid_q && !out_stall_i;
  assign head_free = pop || !head_valid_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (head_free) begin
      head_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= skid_valid_q && push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (head_free) begin
      if (skid_valid_q) begin
        head_q <= skid_q;
        skid_q <= data_i;
      end else begin
        head_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

endmodule

// File: hdl/current_gated_pulse_controller.sv
// ----------------------------------------------------------------------------
// current_gated_pulse_controller
// Per-tick gate controller: one current pulse per enable request, cooldown
// after each pulse or abort, latched fault with a blinking status LED.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Word
//  in      | in        | in_valid_i/in_stall_o | enable_level, current_level
//  out     | out       | out_valid_o/out_stall_i | gate, led, fault, phase
//  cfg     | in        | cfg_valid_i/cfg_ready_o | register index, data
//
//  One tick word per cycle while in_stall_o is low. Its status word is
//  registered in the output head entry, or in the skid entry behind a held
//  head. Phase step and compare logic sit between state and result registers.
//  Reset puts the block in the check phase, gate off, LED on, defaults in
//  the registers. Configuration writes are always ready.
//  A two-entry output buffer absorbs one stalled word; input stalls only
//  once both entries are full.
// ----------------------------------------------------------------------------
module current_gated_pulse_controller #(
  parameter int unsigned COUNTER_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cgpc_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cgpc_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cgpc_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [cgpc_pkg::BLINK_W-1:0] cfg_data_i
);
  import cgpc_pkg::*;

  cfg_t cfg;
  out_t res;
  logic step;
  logic full;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  cgpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cgpc_fsm #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  cgpc_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Gate is only driven in armed or pulse
  a_gate_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gate_drive |->
      (out_data_o.phase_now == CODE_ARMED) || (out_data_o.phase_now == CODE_PULSE))
    else $error("gate on outside armed/pulse");

  // Fault flag tracks the error phase
  a_fault_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fault_latched == (out_data_o.phase_now == CODE_ERROR)))
    else $error("fault flag disagrees with phase");

  // Skid entry only fills behind a held result
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("skid filled without output stall");

  // Stall upstream implies a result is waiting
  a_stall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule
